/* rtl/core/cdus_pkg.sv */
// Shared types and constants for the civil date to Unix seconds core.
// Used by cdus_days and civil_date_to_unix_seconds_core; depends on nothing.
package cdus_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int SECS_W   = 32;

    localparam int YADJ_W = 15;
    localparam int DOY_W  = 9;
    localparam int TOD_W  = 17;
    localparam int DAYS_W = 25;
    localparam int WIDE_W = 45;

    localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = 14'd2020;
    localparam logic [YADJ_W-1:0] YEAR_BIAS      = 15'd400;
    localparam logic [8:0]        DAYS_PER_YEAR  = 9'd365;
    localparam logic [15:0]       RECIP_25       = 16'd41944;
    localparam int                RECIP_SHIFT    = 20;
    localparam logic [23:0]       EPOCH_OFFSET   = 24'd865566;
    localparam logic [16:0]       DAY_SECONDS    = 17'd86400;

    typedef struct packed {
        logic s2_load;
        logic s3_load;
    } stage_en_t;

    function automatic logic [DOY_W-1:0] month_base(input logic [MONTH_W-1:0] month);
        logic [DOY_W-1:0] base;
        case (month)
            4'd0:    base = 9'd275;
            4'd1:    base = 9'd306;
            4'd2:    base = 9'd337;
            4'd3:    base = 9'd0;
            4'd4:    base = 9'd31;
            4'd5:    base = 9'd61;
            4'd6:    base = 9'd92;
            4'd7:    base = 9'd122;
            4'd8:    base = 9'd153;
            4'd9:    base = 9'd184;
            4'd10:   base = 9'd214;
            4'd11:   base = 9'd245;
            4'd12:   base = 9'd275;
            4'd13:   base = 9'd306;
            4'd14:   base = 9'd337;
            default: base = 9'd367;
        endcase
        return base;
    endfunction

endpackage

/* rtl/core/cdus_days.sv */
// Day count stages: Gregorian leap corrections and sum down to days since the epoch.
// Depends on cdus_pkg.
module cdus_days (
    input  logic                                 aclk,
    input  cdus_pkg::stage_en_t                  en,
    input  logic [cdus_pkg::YADJ_W-1:0]          y_adj,
    input  logic [cdus_pkg::DOY_W-1:0]           doy,
    output logic signed [cdus_pkg::DAYS_W-1:0]   days
);
    import cdus_pkg::*;

    logic [22:0]        y365_reg, y365_next;
    logic [12:0]        q4_reg, q4_next;
    logic [8:0]         c100_reg, c100_next;
    logic [6:0]         c400_reg, c400_next;
    logic [DOY_W-1:0]   doy_reg;
    logic [28:0]        prod100;
    logic [26:0]        prod400;
    logic [10:0]        q16;
    logic [23:0]        days_pos;
    logic signed [DAYS_W-1:0] days_reg, days_next;

    always_comb begin
        q4_next   = y_adj[YADJ_W-1:2];
        q16       = y_adj[YADJ_W-1:4];
        prod100   = 29'(q4_next) * 29'(RECIP_25);
        prod400   = 27'(q16) * 27'(RECIP_25);
        c100_next = prod100[28:RECIP_SHIFT];
        c400_next = prod400[26:RECIP_SHIFT];
        y365_next = 23'(y_adj) * 23'(DAYS_PER_YEAR);
    end

    always_ff @(posedge aclk) begin
        if (en.s2_load) begin
            y365_reg <= y365_next;
            q4_reg   <= q4_next;
            c100_reg <= c100_next;
            c400_reg <= c400_next;
            doy_reg  <= doy;
        end
    end

    always_comb begin
        days_pos  = 24'(y365_reg) + 24'(q4_reg) - 24'(c100_reg) + 24'(c400_reg) + 24'(doy_reg);
        days_next = $signed(DAYS_W'(days_pos)) - $signed(DAYS_W'(EPOCH_OFFSET));
    end

    always_ff @(posedge aclk) begin
        if (en.s3_load) begin
            days_reg <= days_next;
        end
    end

    assign days = days_reg;

endmodule

/* rtl/core/civil_date_to_unix_seconds_core.sv */
// Converts a Gregorian date and UTC time of day into 32-bit Unix seconds.
// Depends on cdus_pkg and cdus_days.
//
// The core is a five-stage pipeline that accepts one transaction per clock when the
// output is not held off. Stage boundaries sit after input decode, after the constant
// multiplies for the year terms, after the day sum, after the day-to-seconds multiply,
// and after the range check. Each stage stalls only when the one after it is full, so
// bubbles close up and new transactions are taken while a finished result waits. A
// result is zero when either ok flag is clear, when the year is below min_year (reset
// value 2020), or when the seconds fall outside 0 to 2^32-1. min_year is written
// through cfg_we and cfg_wdata and should only change while the pipeline is empty.
module civil_date_to_unix_seconds_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [cdus_pkg::YEAR_W-1:0]         cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_date_ok,
    input  logic                                s_time_ok,
    input  logic [cdus_pkg::YEAR_W-1:0]         s_year,
    input  logic [cdus_pkg::MONTH_W-1:0]        s_month,
    input  logic [cdus_pkg::DAY_W-1:0]          s_day,
    input  logic [cdus_pkg::HOUR_W-1:0]         s_hour,
    input  logic [cdus_pkg::MINUTE_W-1:0]       s_minute,
    input  logic [cdus_pkg::SECOND_W-1:0]       s_second,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [cdus_pkg::SECS_W-1:0]         m_unix_seconds
);
    import cdus_pkg::*;

    logic [YEAR_W-1:0] min_year_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;
    stage_en_t en_days;

    logic [YADJ_W-1:0] y_adj_reg, y_adj_next;
    logic [DOY_W-1:0]  doy_reg, doy_next;
    logic [TOD_W-1:0]  tod1_reg, tod2_reg, tod3_reg, tod_next;
    logic              ok1_reg, ok2_reg, ok3_reg, ok4_reg, ok5_reg, ok_next;
    logic signed [DAYS_W-1:0] days;
    logic signed [WIDE_W-1:0] secs_reg, secs_next;
    logic [SECS_W-1:0] result_reg, result_next;

    assign en5 = !v5_reg || m_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_year_reg <= MIN_YEAR_RESET;
        end else if (cfg_we) begin
            min_year_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                v4_reg <= v3_reg;
            end
            if (en5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Years run from March, so January, February and month zero belong to the year before.
    always_comb begin
        y_adj_next = YADJ_W'(s_year) + YEAR_BIAS - YADJ_W'(s_month <= 4'd2);
        doy_next   = month_base(s_month) + DOY_W'(s_day);
        tod_next   = TOD_W'(s_hour) * TOD_W'(3600) + TOD_W'(s_minute) * TOD_W'(60)
                   + TOD_W'(s_second);
        ok_next    = s_date_ok && s_time_ok && (s_year >= min_year_reg);
    end

    always_ff @(posedge aclk) begin
        if (en1 && s_valid) begin
            y_adj_reg <= y_adj_next;
            doy_reg   <= doy_next;
            tod1_reg  <= tod_next;
            ok1_reg   <= ok_next;
        end
        if (en2 && v1_reg) begin
            tod2_reg <= tod1_reg;
            ok2_reg  <= ok1_reg;
        end
        if (en3 && v2_reg) begin
            tod3_reg <= tod2_reg;
            ok3_reg  <= ok2_reg;
        end
        if (en4 && v3_reg) begin
            secs_reg <= secs_next;
            ok4_reg  <= ok3_reg;
        end
        if (en5 && v4_reg) begin
            result_reg <= result_next;
            ok5_reg    <= ok4_reg;
        end
    end

    assign en_days.s2_load = en2 && v1_reg;
    assign en_days.s3_load = en3 && v2_reg;

    cdus_days u_days (
        .aclk  (aclk),
        .en    (en_days),
        .y_adj (y_adj_reg),
        .doy   (doy_reg),
        .days  (days)
    );

    always_comb begin
        secs_next = WIDE_W'(days) * $signed({1'b0, DAY_SECONDS})
                  + $signed({{(WIDE_W-TOD_W){1'b0}}, tod3_reg});
        if (ok4_reg && !secs_reg[WIDE_W-1] && (secs_reg[WIDE_W-2:SECS_W] == '0)) begin
            result_next = secs_reg[SECS_W-1:0];
        end else begin
            result_next = '0;
        end
    end

    assign m_valid        = v5_reg;
    assign m_unix_seconds = result_reg;

`ifndef SYNTHESIS
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && en5 && !ok4_reg) |=> (m_valid && m_unix_seconds == '0))
        else $error("rejected transaction produced a nonzero result");

    a_negative_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && en5 && secs_reg[WIDE_W-1]) |=> (m_valid && m_unix_seconds == '0))
        else $error("negative seconds produced a nonzero result");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && !m_ready) |-> !s_ready)
        else $error("full pipeline accepted a transaction while stalled");

    a_flag_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (v5_reg && !ok5_reg) |-> (m_unix_seconds == '0))
        else $error("output result disagrees with its rejection flag");
`endif

endmodule
